[src/rgb_image_bilinear_sampler_core_assert.svh]
// Assertion macros for the bilinear sampler core.
// Used by the top level; needs nothing else.
`ifndef RGB_IMAGE_BILINEAR_SAMPLER_CORE_ASSERT_SVH
`define RGB_IMAGE_BILINEAR_SAMPLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBBS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbbs assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define RGBBS_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("rgbbs assertion failed");

`endif

[src/rgbbs_pkg.sv]
// Shared constants, codes and types of the bilinear sampler core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rgbbs_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int COORD_BITS = 17;
   localparam int COL_BITS   = 8;
   localparam int ROW_BITS   = 8;
   localparam int CHAN_BITS  = 8;
   localparam int DIM_BITS   = 9;
   localparam int OUT_BITS   = 16;
   localparam int CSR_BITS   = 2;
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // Four banks by row and column parity; each holds a quarter of the image.
   localparam int BANK_ADDR_BITS = (COL_BITS - 1) + (ROW_BITS - 1);
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;

   localparam logic [1:0] FUNC_WRITE    = 2'd0;
   localparam logic [1:0] FUNC_BILINEAR = 2'd1;
   localparam logic [1:0] FUNC_NEAREST  = 2'd2;

   localparam logic [CSR_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef logic [3*CHAN_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
   } frac_type;

   typedef struct packed {
      logic valid;
      logic ok;
      logic has_data;
   } ctl_type;

endpackage

`default_nettype wire

[src/rgbbs_bank.sv]
// One bank of the pixel store: single port, registered read data.
// Depends on rgbbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbbs_bank (
   input  wire logic                               clock,
   input  wire logic                               we,
   input  wire logic [rgbbs_pkg::BANK_ADDR_BITS-1:0] addr,
   input  wire rgbbs_pkg::pixel_type               wdata,
   output rgbbs_pkg::pixel_type                    rdata
);
   import rgbbs_pkg::*;

   pixel_type mem [0:BANK_DEPTH-1];
   pixel_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/rgbbs_lerp.sv]
// Two-stage bilinear blend of one color channel: horizontal, then vertical
// with rounding to 8.8. Depends on rgbbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbbs_lerp (
   input  wire logic                            clock,
   input  wire logic [rgbbs_pkg::CHAN_BITS-1:0] p00,
   input  wire logic [rgbbs_pkg::CHAN_BITS-1:0] p10,
   input  wire logic [rgbbs_pkg::CHAN_BITS-1:0] p01,
   input  wire logic [rgbbs_pkg::CHAN_BITS-1:0] p11,
   input  wire rgbbs_pkg::frac_type             frac,
   output logic [rgbbs_pkg::OUT_BITS-1:0]       result
);
   import rgbbs_pkg::*;

   localparam int WGT_BITS  = FRAC_BITS + 1;
   localparam int PROD_BITS = CHAN_BITS + WGT_BITS;
   localparam int H_BITS    = CHAN_BITS + FRAC_BITS;
   localparam int V_BITS    = H_BITS + WGT_BITS;
   localparam int SHIFT     = 2 * FRAC_BITS - 8;
   localparam logic [WGT_BITS-1:0] ONE   = WGT_BITS'(1 << FRAC_BITS);
   localparam logic [V_BITS-1:0]   ROUND = V_BITS'(1 << (SHIFT - 1));

   logic [WGT_BITS-1:0]  inv_fx, fx_w, inv_fy, fy_w;
   logic [PROD_BITS-1:0] a0, b0, a1, b1;
   logic [PROD_BITS:0]   sum0, sum1;
   logic [H_BITS-1:0]    h0_in, h1_in, h0_ff, h1_ff;
   logic [FRAC_BITS-1:0] fy_ff;
   logic [V_BITS-1:0]    v0, v1, total;
   logic [OUT_BITS-1:0]  result_in, result_ff;

   always_comb begin
      fx_w   = {1'b0, frac.fx};
      inv_fx = ONE - fx_w;
      a0     = {{WGT_BITS{1'b0}}, p00} * {{CHAN_BITS{1'b0}}, inv_fx};
      b0     = {{WGT_BITS{1'b0}}, p10} * {{CHAN_BITS{1'b0}}, fx_w};
      a1     = {{WGT_BITS{1'b0}}, p01} * {{CHAN_BITS{1'b0}}, inv_fx};
      b1     = {{WGT_BITS{1'b0}}, p11} * {{CHAN_BITS{1'b0}}, fx_w};
      // A blend of two bytes never exceeds 255 * 256, so the top bits are zero.
      sum0   = {1'b0, a0} + {1'b0, b0};
      sum1   = {1'b0, a1} + {1'b0, b1};
      h0_in  = sum0[H_BITS-1:0];
      h1_in  = sum1[H_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      h0_ff <= h0_in;
      h1_ff <= h1_in;
      fy_ff <= frac.fy;
   end

   always_comb begin
      fy_w      = {1'b0, fy_ff};
      inv_fy    = ONE - fy_w;
      v0        = {{WGT_BITS{1'b0}}, h0_ff} * {{H_BITS{1'b0}}, inv_fy};
      v1        = {{WGT_BITS{1'b0}}, h1_ff} * {{H_BITS{1'b0}}, fy_w};
      total     = v0 + v1 + ROUND;
      result_in = total[SHIFT+OUT_BITS-1:SHIFT];
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[src/rgb_image_bilinear_sampler_core.sv]
// Top level of the RGB image bilinear sampler: pixel store in four banks,
// address logic, control pipeline. Depends on rgbbs_pkg, rgbbs_bank,
// rgbbs_lerp and rgb_image_bilinear_sampler_core_assert.svh.
//
// Usage: the configuration channel (csr_valid/csr_ready, csr_index, csr_wdata)
// sets image_width (index 0) and image_height (index 1); values above 256 are
// saturated, zero means an empty image. Write it only while no beat is in
// flight. A request beat is taken at each edge where start is high and busy is
// low; busy never rises, so a beat can be taken every cycle. req_func selects a
// pixel write, a bilinear sample or a nearest sample.
// Each request gives exactly one response beat, held on the rsp_ ports for one
// cycle with rsp_strobe high. The pipeline depth is set by the registered read
// of the pixel banks followed by the two multiply stages of the blend. The store
// has four banks by row and column parity, so the four neighbours of a sample
// are read together in the same cycle. A pixel write lands at its request edge,
// so a sample in the next cycle already sees it.
// The receiver cannot stall; responses must be taken as they appear.
// Reset clears both dimensions and empties the pipeline. The store contents
// are not cleared and are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_image_bilinear_sampler_core_assert.svh"

module rgb_image_bilinear_sampler_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_func,
   input  wire logic signed [rgbbs_pkg::COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [rgbbs_pkg::COORD_BITS-1:0] req_coord_y,
   input  wire logic [rgbbs_pkg::COL_BITS-1:0]    req_write_col,
   input  wire logic [rgbbs_pkg::ROW_BITS-1:0]    req_write_row,
   input  wire logic [rgbbs_pkg::CHAN_BITS-1:0]   req_write_red,
   input  wire logic [rgbbs_pkg::CHAN_BITS-1:0]   req_write_green,
   input  wire logic [rgbbs_pkg::CHAN_BITS-1:0]   req_write_blue,
   output logic                                   rsp_strobe,
   output logic                                   rsp_ok,
   output logic [rgbbs_pkg::OUT_BITS-1:0]         rsp_red_out,
   output logic [rgbbs_pkg::OUT_BITS-1:0]         rsp_green_out,
   output logic [rgbbs_pkg::OUT_BITS-1:0]         rsp_blue_out,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rgbbs_pkg::CSR_BITS-1:0]    csr_index,
   input  wire logic [rgbbs_pkg::DIM_BITS-1:0]    csr_wdata
);
   import rgbbs_pkg::*;

   localparam logic [DIM_BITS-1:0] WIDTH_CAP  = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] HEIGHT_CAP = DIM_BITS'(MAX_HEIGHT);
   localparam logic signed [COORD_BITS:0] HALF = (COORD_BITS+1)'(1 << (FRAC_BITS - 1));

   logic [DIM_BITS-1:0] width_ff, height_ff;

   // Configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= (csr_wdata > WIDTH_CAP) ? WIDTH_CAP : csr_wdata;
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= (csr_wdata > HEIGHT_CAP) ? HEIGHT_CAP : csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Request decode and neighbour addresses
   logic                   accept;
   logic                   nonempty;
   logic [COL_BITS-1:0]    w_last;
   logic [ROW_BITS-1:0]    h_last;
   logic                   bx_in, by_in, nx_in, ny_in;
   logic [DIM_BITS-1:0]    bx0_inc, by0_inc;
   logic [COL_BITS-1:0]    bx1;
   logic [ROW_BITS-1:0]    by1;
   logic signed [COORD_BITS:0] tx, ty;
   logic [DIM_BITS-1:0]    nxi, nyi;
   logic [COL_BITS-1:0]    x0, x1;
   logic [ROW_BITS-1:0]    y0, y1;
   frac_type               frac_in;
   logic                   is_write, wr_ok, samp_ok;
   pixel_type              wr_pixel;
   ctl_type                c0;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      nonempty = (width_ff != '0) && (height_ff != '0);
      w_last   = COL_BITS'(width_ff - 1'b1);
      h_last   = ROW_BITS'(height_ff - 1'b1);

      // Bilinear: exact bounds, right and bottom neighbours clamped at the edge.
      bx_in   = !req_coord_x[COORD_BITS-1] &&
                (req_coord_x[COORD_BITS-2:0] <= {w_last, {FRAC_BITS{1'b0}}});
      by_in   = !req_coord_y[COORD_BITS-1] &&
                (req_coord_y[COORD_BITS-2:0] <= {h_last, {FRAC_BITS{1'b0}}});
      bx0_inc = {1'b0, req_coord_x[COORD_BITS-2:FRAC_BITS]} + 1'b1;
      by0_inc = {1'b0, req_coord_y[COORD_BITS-2:FRAC_BITS]} + 1'b1;
      bx1     = (bx0_inc < width_ff)  ? bx0_inc[COL_BITS-1:0] : w_last;
      by1     = (by0_inc < height_ff) ? by0_inc[ROW_BITS-1:0] : h_last;

      // Nearest: round half away from zero. Adding one half and keeping the
      // positive results covers the negative coordinates that round to zero.
      tx    = {req_coord_x[COORD_BITS-1], req_coord_x} + HALF;
      ty    = {req_coord_y[COORD_BITS-1], req_coord_y} + HALF;
      nxi   = tx[COORD_BITS-1:FRAC_BITS];
      nyi   = ty[COORD_BITS-1:FRAC_BITS];
      nx_in = !tx[COORD_BITS] && (tx != '0) && (nxi < width_ff);
      ny_in = !ty[COORD_BITS] && (ty != '0) && (nyi < height_ff);

      if (req_func == FUNC_NEAREST) begin
         x0      = nxi[COL_BITS-1:0];
         x1      = nxi[COL_BITS-1:0];
         y0      = nyi[ROW_BITS-1:0];
         y1      = nyi[ROW_BITS-1:0];
         frac_in = '0;
      end else begin
         x0         = req_coord_x[COORD_BITS-2:FRAC_BITS];
         x1         = bx1;
         y0         = req_coord_y[COORD_BITS-2:FRAC_BITS];
         y1         = by1;
         frac_in.fx = req_coord_x[FRAC_BITS-1:0];
         frac_in.fy = req_coord_y[FRAC_BITS-1:0];
      end

      is_write = (req_func == FUNC_WRITE);
      wr_ok    = is_write && ({1'b0, req_write_col} < width_ff) &&
                 ({1'b0, req_write_row} < height_ff);
      samp_ok  = nonempty &&
                 (((req_func == FUNC_BILINEAR) && bx_in && by_in) ||
                  ((req_func == FUNC_NEAREST) && nx_in && ny_in));
      wr_pixel = {req_write_red, req_write_green, req_write_blue};

      c0.valid    = accept;
      c0.ok       = wr_ok || samp_ok;
      c0.has_data = samp_ok;
   end

   // Pixel banks, indexed [row parity][column parity]
   logic [BANK_ADDR_BITS-1:0] bank_addr  [0:1][0:1];
   logic                      bank_we    [0:1][0:1];
   pixel_type                 bank_rdata [0:1][0:1];

   for (genvar r = 0; r < 2; r++) begin : g_row
      for (genvar c = 0; c < 2; c++) begin : g_col
         logic [COL_BITS-1:0] rd_col;
         logic [ROW_BITS-1:0] rd_row;

         // Of two adjacent columns exactly one has this bank's parity; when
         // clamped both are the same column and this bank may go unused.
         assign rd_col = (x0[0] == 1'(c)) ? x0 : x1;
         assign rd_row = (y0[0] == 1'(r)) ? y0 : y1;

         assign bank_we[r][c] = accept && wr_ok &&
                                (req_write_row[0] == 1'(r)) &&
                                (req_write_col[0] == 1'(c));
         assign bank_addr[r][c] = is_write ?
            {req_write_row[ROW_BITS-1:1], req_write_col[COL_BITS-1:1]} :
            {rd_row[ROW_BITS-1:1], rd_col[COL_BITS-1:1]};

         rgbbs_bank u_bank (
            .clock (clock),
            .we    (bank_we[r][c]),
            .addr  (bank_addr[r][c]),
            .wdata (wr_pixel),
            .rdata (bank_rdata[r][c])
         );
      end
   end

   // Stage 1: bank data arrives; select the four neighbours
   ctl_type  c1_ff, c2_ff, c3_ff;
   frac_type frac1_ff;
   logic     x0p_ff, x1p_ff, y0p_ff, y1p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else begin
         c1_ff <= c0;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
      frac1_ff <= frac_in;
      x0p_ff   <= x0[0];
      x1p_ff   <= x1[0];
      y0p_ff   <= y0[0];
      y1p_ff   <= y1[0];
   end

   pixel_type p00, p10, p01, p11;

   always_comb begin
      p00 = bank_rdata[y0p_ff][x0p_ff];
      p10 = bank_rdata[y0p_ff][x1p_ff];
      p01 = bank_rdata[y1p_ff][x0p_ff];
      p11 = bank_rdata[y1p_ff][x1p_ff];
   end

   // Stages 2 and 3: one blend per channel
   logic [OUT_BITS-1:0] red_res, green_res, blue_res;

   rgbbs_lerp u_lerp_red (
      .clock  (clock),
      .p00    (p00[3*CHAN_BITS-1:2*CHAN_BITS]),
      .p10    (p10[3*CHAN_BITS-1:2*CHAN_BITS]),
      .p01    (p01[3*CHAN_BITS-1:2*CHAN_BITS]),
      .p11    (p11[3*CHAN_BITS-1:2*CHAN_BITS]),
      .frac   (frac1_ff),
      .result (red_res)
   );

   rgbbs_lerp u_lerp_green (
      .clock  (clock),
      .p00    (p00[2*CHAN_BITS-1:CHAN_BITS]),
      .p10    (p10[2*CHAN_BITS-1:CHAN_BITS]),
      .p01    (p01[2*CHAN_BITS-1:CHAN_BITS]),
      .p11    (p11[2*CHAN_BITS-1:CHAN_BITS]),
      .frac   (frac1_ff),
      .result (green_res)
   );

   rgbbs_lerp u_lerp_blue (
      .clock  (clock),
      .p00    (p00[CHAN_BITS-1:0]),
      .p10    (p10[CHAN_BITS-1:0]),
      .p01    (p01[CHAN_BITS-1:0]),
      .p11    (p11[CHAN_BITS-1:0]),
      .frac   (frac1_ff),
      .result (blue_res)
   );

   // Writes and failed samples show zero color.
   assign rsp_strobe    = c3_ff.valid;
   assign rsp_ok        = c3_ff.ok;
   assign rsp_red_out   = c3_ff.has_data ? red_res   : '0;
   assign rsp_green_out = c3_ff.has_data ? green_res : '0;
   assign rsp_blue_out  = c3_ff.has_data ? blue_res  : '0;

   // Assertions
   `RGBBS_ASSERT_DELAY(a_beat_to_response, clock, reset, accept, 3, rsp_strobe)
   `RGBBS_ASSERT_IMPLY(a_response_has_beat, clock, reset, rsp_strobe, $past(accept, 3))
   `RGBBS_ASSERT_DELAY(a_write_in_bounds_ok, clock, reset, accept && wr_ok, 3, rsp_ok)

endmodule

`default_nettype wire
